[rtl/palette_nearest_colour_quantizer_macros.svh]
// ----------------------------------------------------------------------------
// palette_nearest_colour_quantizer_macros.svh
// assertion macros used by the quantizer controller, pnq_ctrl
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOUR_QUANTIZER_MACROS_SVH
`define PALETTE_NEAREST_COLOUR_QUANTIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PNQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PNQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pnq_pkg.sv]
// ----------------------------------------------------------------------------
// pnq_pkg
// types, widths and constants of the nearest palette colour quantizer
// ----------------------------------------------------------------------------
package pnq_pkg;

	localparam int PAL_ENTRIES = 16;
	localparam int IDX_W       = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int COMP_W      = 8;
	localparam int SQ_W        = 2 * COMP_W;
	localparam int DIST_W      = SQ_W + 2;
	localparam int ENTRY_W     = 4;
	localparam int ALPHA_W     = 8;
	localparam int COLOUR_W    = 4;

	localparam int S_FIELDS_W  = ENTRY_W + 3 * COMP_W + ALPHA_W;
	localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((COLOUR_W + 7) / 8) * 8;

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} pnq_rgb_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} pnq_state_t;

	typedef struct packed {
		logic load;
		logic write;
		logic scan_en;
		logic emit;
	} pnq_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic pipe_empty;
		logic out_free;
	} pnq_stat_t;

endpackage

[rtl/pnq_dp.sv]
// ----------------------------------------------------------------------------
// pnq_dp
// palette store, distance pipeline, best-entry tracking and result register
// ----------------------------------------------------------------------------
module pnq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pnq_pkg::pnq_cmd_t             cmd,
	output pnq_pkg::pnq_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [pnq_pkg::ALPHA_W-1:0]   cfg_wdata,
	input  logic [pnq_pkg::ENTRY_W-1:0]   entry,
	input  pnq_pkg::pnq_rgb_t             colour,
	input  logic [pnq_pkg::ALPHA_W-1:0]   alpha,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [pnq_pkg::COLOUR_W-1:0]  res_index,
	output logic                          res_opaque
);
	import pnq_pkg::*;

	pnq_rgb_t            pal_q [PAL_ENTRIES];
	logic [ALPHA_W-1:0]  thresh_q;
	pnq_rgb_t            colour_q;
	logic                opaque_q;
	logic [IDX_W-1:0]    idx_q;

	logic                v_s1;
	logic [COMP_W-1:0]   dr_s1, dg_s1, db_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                v_s2;
	logic [SQ_W-1:0]     sr_s2, sg_s2, sb_s2;
	logic [IDX_W-1:0]    idx_s2;

	logic [DIST_W-1:0]   best_dist_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic                out_valid_q;
	logic [COLOUR_W-1:0] out_idx_q;
	logic                out_opaque_q;

	pnq_rgb_t            rd_entry;
	logic [DIST_W-1:0]   dist_sum;
	logic                entry_ok;

	function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	assign entry_ok = (32'(entry) < PAL_ENTRIES);
	assign rd_entry = pal_q[idx_q];
	assign dist_sum = DIST_W'(sr_s2) + DIST_W'(sg_s2) + DIST_W'(sb_s2);

	// palette, reset to black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAL_ENTRIES; i++) begin
				pal_q[i] <= '0;
			end
		end else if (cmd.write && entry_ok) begin
			pal_q[IDX_W'(entry)] <= colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.scan_en) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			colour_q <= colour;
			opaque_q <= (alpha >= thresh_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dr_s1  <= abs_diff(colour_q.red, rd_entry.red);
		dg_s1  <= abs_diff(colour_q.green, rd_entry.green);
		db_s1  <= abs_diff(colour_q.blue, rd_entry.blue);
		idx_s1 <= idx_q;
		sr_s2  <= dr_s1 * dr_s1;
		sg_s2  <= dg_s1 * dg_s1;
		sb_s2  <= db_s1 * db_s1;
		idx_s2 <= idx_s1;
	end

	// strict less keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_dist_q <= '1;
			best_idx_q  <= '0;
		end else if (v_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q    <= COLOUR_W'(best_idx_q);
			out_opaque_q <= opaque_q;
		end
	end

	assign stat.idx_last   = (idx_q == IDX_W'(PAL_ENTRIES - 1));
	assign stat.pipe_empty = !v_s1 && !v_s2;
	assign stat.out_free   = !out_valid_q || res_ready;

	assign res_valid  = out_valid_q;
	assign res_index  = out_idx_q;
	assign res_opaque = out_opaque_q;

endmodule

[rtl/pnq_ctrl.sv]
// ----------------------------------------------------------------------------
// pnq_ctrl
// sequencer: accepts beats, runs the palette scan, hands off the result
// ----------------------------------------------------------------------------
`include "palette_nearest_colour_quantizer_macros.svh"

module pnq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_cmd,
	output pnq_pkg::pnq_cmd_t  cmd,
	input  pnq_pkg::pnq_stat_t stat
);
	import pnq_pkg::*;

	pnq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == CMD_CONVERT) begin
						cmd.load = 1'b1;
						state_d  = ST_SCAN;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty && stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`PNQ_ASSERT_IMP(a_emit_safe, cmd.emit, stat.pipe_empty && stat.out_free, "result loaded early")
	`PNQ_ASSERT_NXT(a_scan_start, cmd.load, (state_q == ST_SCAN) && !stat.idx_last, "scan start bad")
	`PNQ_ASSERT_NXT(a_scan_hold, (state_q == ST_SCAN) && !stat.idx_last, state_q == ST_SCAN,
		"scan cut short")

endmodule

[rtl/palette_nearest_colour_quantizer.sv]
// ----------------------------------------------------------------------------
// palette_nearest_colour_quantizer
// nearest palette entry by squared euclidean distance, with opaque flag
//
// input beats on s_axis: tuser selects write (0) or convert (1). a write beat
// stores one palette entry and gives no output beat. a convert beat scans the
// 16 entries, one per cycle through the difference, square and compare
// stages, and gives one output beat on m_axis with the nearest index in
// tdata and the opaque flag in tuser; ties go to the lowest index.
// after the accepting edge a convert scans the palette, then drains the
// pipeline and loads the result register once it is free, which raises
// m_axis_tvalid; the next beat is taken only after that, so converts do not
// overlap, as the single compare unit walks the palette. write beats can
// follow each other every cycle. s_axis_tready is high only between items.
// the result waits in an output register: a stalled receiver does not stop a
// following write beat, and a following convert finishes its scan and waits
// until the held result is taken.
// reset clears the palette to black and the alpha threshold to zero; cfg_we
// writes it; the user must write it only while idle, the block does not check.
// ----------------------------------------------------------------------------
module palette_nearest_colour_quantizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pnq_pkg::ALPHA_W-1:0]    cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// entry, red, green, blue, alpha, zero fill
	input  logic [pnq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic [0:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// colour_index, zero fill
	output logic [pnq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// opaque
	output logic [0:0]                     m_axis_tuser
);
	import pnq_pkg::*;

	pnq_cmd_t            cmd;
	pnq_stat_t           stat;
	logic [ENTRY_W-1:0]  entry;
	pnq_rgb_t            colour;
	logic [ALPHA_W-1:0]  alpha;
	logic [COLOUR_W-1:0] res_index;
	logic                res_opaque;

	assign entry        = s_axis_tdata[ENTRY_W-1:0];
	assign colour.red   = s_axis_tdata[ENTRY_W +: COMP_W];
	assign colour.green = s_axis_tdata[ENTRY_W + COMP_W +: COMP_W];
	assign colour.blue  = s_axis_tdata[ENTRY_W + 2 * COMP_W +: COMP_W];
	assign alpha        = s_axis_tdata[ENTRY_W + 3 * COMP_W +: ALPHA_W];

	pnq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser[0]),
		.cmd      (cmd),
		.stat     (stat)
	);

	pnq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.entry      (entry),
		.colour     (colour),
		.alpha      (alpha),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_index  (res_index),
		.res_opaque (res_opaque)
	);

	assign m_axis_tdata    = M_TDATA_W'(res_index);
	assign m_axis_tuser[0] = res_opaque;

endmodule
